// File: src/multicast_membership_table_macros.svh
// Assertion macros shared by the membership table RTL.
`ifndef MULTICAST_MEMBERSHIP_TABLE_MACROS_SVH
`define MULTICAST_MEMBERSHIP_TABLE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MMT_ASSERT_IMPL(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define MMT_ASSERT_NEVER(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define MMT_ASSERT_IMPL(label, clk, rstn, prop, msg)
`define MMT_ASSERT_NEVER(label, clk, rstn, cond, msg)
`endif
`endif

// File: src/mmt_pkg.sv
// Types and constants of the multicast membership table.
`default_nettype none
package mmt_pkg;
  localparam int unsigned NumCfgRegs = 2;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 40;
  localparam logic [CfgIdxW-1:0] CfgSelfAddress = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgLikeExpire = 1'd1;
  localparam logic [31:0] LikeExpireReset = 32'd600000;

  localparam logic [1:0] OpAdd = 2'd0;
  localparam logic [1:0] OpRemove = 2'd1;
  localparam logic [1:0] OpExpire = 2'd2;

  localparam logic [2:0] StAdded = 3'd0;
  localparam logic [2:0] StRefreshed = 3'd1;
  localparam logic [2:0] StSelf = 3'd2;
  localparam logic [2:0] StMembersFull = 3'd3;
  localparam logic [2:0] StGroupsFull = 3'd4;
  localparam logic [2:0] StRemoved = 3'd5;
  localparam logic [2:0] StNotFound = 3'd6;
  localparam logic [2:0] StSwept = 3'd7;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] network_id;
    logic [47:0] group_mac;
    logic [31:0] group_adi;
    logic [39:0] member_address;
    logic [63:0] now;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [8:0]  member_count;
    logic [12:0] expired_count;
  } rsp_t;

  // One member entry as stored in the member memory.
  typedef struct packed {
    logic [39:0] addr;
    logic [63:0] seen;
  } member_t;
endpackage
`default_nettype wire

// File: src/mmt_member_ram.sv
// Member memory with one write port and one registered read port.
`default_nettype none
module mmt_member_ram #(
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire mmt_pkg::member_t         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output mmt_pkg::member_t              rdata_o
);
  mmt_pkg::member_t mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// File: src/multicast_membership_table.sv
// Top level of the multicast membership table with aging.
//
//  channel | direction | signals                     | beat
//  in      | input     | in_valid_i/in_stall_o/in_i  | one request
//  out     | output    | out_valid_o/out_stall_i/out_o | one response
//  cfg     | input     | cfg_we_i/cfg_idx_i/cfg_data_i | one register write
//
// Requests are worked one at a time. Group lookup walks the slots, one per cycle, and
// an add to a new group walks them again to allocate. Members are scanned through the
// member memory in states S_MREAD and S_MCHECK; remove compaction moves one entry per
// S_SHREAD/S_SHWRITE pair. A sweep visits each stored member in S_SWREAD and S_SWCHECK,
// plus S_SWMOVE for a kept one, and each slot in S_SWGRP and S_SWEND.
// Reset clears group valid bits and sizes at once; no clearing pass is needed.
// While a response waits under out_stall_i, no new request is taken.
`default_nettype none
`include "multicast_membership_table_macros.svh"
module multicast_membership_table #(
  parameter int unsigned GROUP_SLOTS = 16,
  parameter int unsigned MEMBERS_PER_GROUP = 256
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire mmt_pkg::req_t                in_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output mmt_pkg::rsp_t                     out_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [mmt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mmt_pkg::CfgDataW-1:0] cfg_data_i
);
  localparam int unsigned GW = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
  localparam int unsigned MW = $clog2(MEMBERS_PER_GROUP);
  localparam int unsigned CW = $clog2(MEMBERS_PER_GROUP + 1);
  localparam int unsigned Depth = GROUP_SLOTS * MEMBERS_PER_GROUP;
  localparam int unsigned AW = $clog2(Depth);
  localparam logic [CW-1:0] MaxMembers = CW'(MEMBERS_PER_GROUP);
  localparam logic [GW-1:0] LastSlot = GW'(GROUP_SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_ALLOC, S_DECIDE, S_MREAD, S_MCHECK, S_SHREAD, S_SHWRITE,
    S_SWGRP, S_SWREAD, S_SWCHECK, S_SWMOVE, S_SWEND, S_RESP
  } state_e;

  // Configuration registers.
  logic [39:0] self_q;
  logic [31:0] expire_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_q <= '0;
      expire_q <= mmt_pkg::LikeExpireReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mmt_pkg::CfgSelfAddress: self_q <= cfg_data_i;
        mmt_pkg::CfgLikeExpire: expire_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Group table: valid bits and sizes reset, keys written on allocation.
  logic [GROUP_SLOTS-1:0] used_q;
  logic [CW-1:0]  size_q [GROUP_SLOTS];
  logic [63:0] net_q [GROUP_SLOTS];
  logic [47:0] mac_q [GROUP_SLOTS];
  logic [31:0] adi_q [GROUP_SLOTS];

  state_e state_q;
  mmt_pkg::req_t req_q;
  mmt_pkg::rsp_t rsp_q;
  logic [GW-1:0] g_q;
  logic [CW-1:0] i_q, j_q, wr_q;
  logic [12:0] exp_q;

  // Member memory.
  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  mmt_pkg::member_t ram_wdata, ram_rdata;
  mmt_member_ram #(.Depth(Depth)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  function automatic logic [AW-1:0] maddr(logic [GW-1:0] g, logic [CW-1:0] i);
    return AW'(32'(g) * MEMBERS_PER_GROUP + 32'(i[MW-1:0]));
  endfunction

  logic key_hit;
  assign key_hit = used_q[g_q] && net_q[g_q] == req_q.network_id &&
                   mac_q[g_q] == req_q.group_mac && adi_q[g_q] == req_q.group_adi;
  logic [63:0] age;
  assign age = req_q.now - ram_rdata.seen;
  logic [CW-1:0] gsize;
  assign gsize = size_q[g_q];

  // Outcome of one member scan step.
  logic scan_hit, scan_end;
  assign scan_hit = (gsize != '0) && (ram_rdata.addr == req_q.member_address);
  assign scan_end = !scan_hit && (i_q >= gsize);

  // Memory port control, driven from the state.
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = maddr(g_q, wr_q);
    ram_wdata = ram_rdata;
    ram_raddr = maddr(g_q, i_q);
    case (state_q)
      S_DECIDE: begin
        ram_waddr = maddr(g_q, gsize);
        ram_wdata = '{addr: req_q.member_address, seen: req_q.now};
      end
      S_SHREAD: ram_raddr = maddr(g_q, j_q);
      S_SWREAD: ram_raddr = maddr(g_q, j_q);
      S_SWCHECK: ram_raddr = maddr(g_q, j_q);
      S_SHWRITE: ram_we = 1'b1;
      S_SWMOVE: ram_we = 1'b1;
      default: ;
    endcase
    if (state_q == S_MCHECK && scan_hit && req_q.op == mmt_pkg::OpAdd) begin
      ram_we = 1'b1;
      ram_waddr = maddr(g_q, i_q - CW'(1));
      ram_wdata = '{addr: ram_rdata.addr, seen: req_q.now};
    end
    if (state_q == S_MCHECK && scan_end && req_q.op == mmt_pkg::OpAdd) begin
      ram_we = 1'b1;
      ram_waddr = maddr(g_q, gsize);
      ram_wdata = '{addr: req_q.member_address, seen: req_q.now};
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_RESP);
  assign out_o = rsp_q;

  // Sequencer: lookup, member scan, compaction and sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q <= '0;
      for (int k = 0; k < GROUP_SLOTS; k++) size_q[k] <= '0;
      g_q <= '0;
      i_q <= '0; j_q <= '0; wr_q <= '0; exp_q <= '0;
      rsp_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i) begin
          req_q <= in_i;
          g_q <= '0; exp_q <= '0;
          rsp_q <= '{status: mmt_pkg::StNotFound, member_count: '0, expired_count: '0};
          case (in_i.op)
            mmt_pkg::OpAdd, mmt_pkg::OpRemove: state_q <= S_FIND;
            mmt_pkg::OpExpire: state_q <= S_SWGRP;
            default: state_q <= S_RESP;
          endcase
        end
        S_FIND: begin
          if (key_hit) begin
            i_q <= '0;
            if (req_q.op == mmt_pkg::OpAdd) state_q <= S_DECIDE;
            else if (gsize == '0) state_q <= S_RESP;
            else state_q <= S_MREAD;
          end else if (g_q == LastSlot) begin
            if (req_q.op == mmt_pkg::OpAdd) begin
              g_q <= '0; state_q <= S_ALLOC;
            end else state_q <= S_RESP;
          end else g_q <= g_q + GW'(1);
        end
        S_ALLOC: begin
          if (!used_q[g_q]) begin
            used_q[g_q] <= 1'b1;
            net_q[g_q] <= req_q.network_id;
            mac_q[g_q] <= req_q.group_mac;
            adi_q[g_q] <= req_q.group_adi;
            size_q[g_q] <= '0;
            i_q <= '0;
            state_q <= S_DECIDE;
          end else if (g_q == LastSlot) begin
            rsp_q.status <= mmt_pkg::StGroupsFull;
            state_q <= S_RESP;
          end else g_q <= g_q + GW'(1);
        end
        S_DECIDE: begin
          rsp_q.member_count <= 9'(gsize);
          if (req_q.member_address == self_q) begin
            rsp_q.status <= mmt_pkg::StSelf; state_q <= S_RESP;
          end else if (gsize >= MaxMembers) begin
            rsp_q.status <= mmt_pkg::StMembersFull; state_q <= S_RESP;
          end else if (gsize == '0) begin
            // Empty group: append directly via the memory write in S_MCHECK path.
            i_q <= '0; state_q <= S_MREAD;
          end else state_q <= S_MREAD;
        end
        S_MREAD: begin
          // Read of entry i issued; empty add goes straight to append.
          i_q <= i_q + CW'(1);
          state_q <= S_MCHECK;
        end
        S_MCHECK: begin
          if (scan_hit) begin
            if (req_q.op == mmt_pkg::OpAdd) begin
              rsp_q.status <= mmt_pkg::StRefreshed;
              state_q <= S_RESP;
            end else begin
              rsp_q.status <= mmt_pkg::StRemoved;
              j_q <= i_q; wr_q <= i_q - CW'(1);
              state_q <= S_SHREAD;
            end
          end else if (i_q >= gsize) begin
            if (req_q.op == mmt_pkg::OpAdd) begin
              rsp_q.status <= mmt_pkg::StAdded;
              size_q[g_q] <= gsize + CW'(1);
              rsp_q.member_count <= 9'(gsize + CW'(1));
            end else rsp_q.member_count <= 9'(gsize);
            state_q <= S_RESP;
          end else state_q <= S_MREAD;
        end
        S_SHREAD: begin
          if (j_q >= gsize) begin
            size_q[g_q] <= gsize - CW'(1);
            rsp_q.member_count <= 9'(gsize - CW'(1));
            state_q <= S_RESP;
          end else state_q <= S_SHWRITE;
        end
        S_SHWRITE: begin
          j_q <= j_q + CW'(1); wr_q <= wr_q + CW'(1);
          state_q <= S_SHREAD;
        end
        S_SWGRP: begin
          i_q <= '0; j_q <= '0; wr_q <= '0;
          state_q <= used_q[g_q] ? S_SWREAD : S_SWEND;
        end
        S_SWREAD: begin
          if (j_q >= gsize) begin
            size_q[g_q] <= wr_q;
            if (wr_q == '0) used_q[g_q] <= 1'b0;
            state_q <= S_SWEND;
          end else state_q <= S_SWCHECK;
        end
        S_SWCHECK: begin
          j_q <= j_q + CW'(1);
          if (age > 64'(expire_q)) begin
            exp_q <= exp_q + 13'd1;
            state_q <= S_SWREAD;
          end else state_q <= S_SWMOVE;
        end
        S_SWMOVE: begin
          wr_q <= wr_q + CW'(1);
          state_q <= S_SWREAD;
        end
        S_SWEND: begin
          if (g_q == LastSlot) begin
            rsp_q <= '{status: mmt_pkg::StSwept, member_count: '0, expired_count: exp_q};
            state_q <= S_RESP;
          end else begin
            g_q <= g_q + GW'(1);
            state_q <= S_SWGRP;
          end
        end
        S_RESP: if (!out_stall_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `MMT_ASSERT_IMPL(a_resp_holds, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o), "response changed under stall")
  `MMT_ASSERT_NEVER(a_no_accept_busy, clk_i, rst_ni, !in_stall_o && state_q != S_IDLE, "ready while busy")
  `MMT_ASSERT_IMPL(a_size_bound, clk_i, rst_ni, state_q == S_RESP |-> rsp_q.member_count <= 9'(MEMBERS_PER_GROUP), "count above limit")
endmodule
`default_nettype wire

// File: bench/multicast_membership_table_tb.sv
// Self-checking regression bench for the multicast membership table.
`timescale 1ns / 100ps
`default_nettype none

module multicast_membership_table_tb;
  localparam int unsigned Slots = 16;
  localparam int unsigned MaxMembers = 256;
  localparam int unsigned StallLimit = 200000;

  // Group table predictor with its own copy of state and registers.
  class membership_scoreboard;
    logic [39:0] self_addr;
    logic [31:0] expire_age;
    bit          used [Slots];
    logic [63:0] key_net [Slots];
    logic [47:0] key_mac [Slots];
    logic [31:0] key_adi [Slots];
    int unsigned size [Slots];
    logic [39:0] addr [Slots][MaxMembers];
    logic [63:0] seen [Slots][MaxMembers];
    mmt_pkg::rsp_t pending_rsp [$];
    int unsigned errors;

    function new();
      self_addr = '0;
      expire_age = mmt_pkg::LikeExpireReset;
      errors = 0;
      foreach (used[g]) begin
        used[g] = 0;
        size[g] = 0;
      end
    endfunction

    function void write_reg(logic [mmt_pkg::CfgIdxW-1:0] idx,
                            logic [mmt_pkg::CfgDataW-1:0] data);
      if (idx == mmt_pkg::CfgSelfAddress) self_addr = data;
      else expire_age = data[31:0];
    endfunction

    function int lookup_group(mmt_pkg::req_t r);
      for (int g = 0; g < Slots; g++)
        if (used[g] && key_net[g] == r.network_id && key_mac[g] == r.group_mac &&
            key_adi[g] == r.group_adi)
          return g;
      return -1;
    endfunction

    function int lookup_member(int g, logic [39:0] a);
      for (int i = 0; i < size[g]; i++)
        if (addr[g][i] == a) return i;
      return -1;
    endfunction

    function void compact(int g, int at);
      for (int j = at; j + 1 < size[g]; j++) begin
        addr[g][j] = addr[g][j+1];
        seen[g][j] = seen[g][j+1];
      end
      size[g]--;
    endfunction

    // Note one accepted request and queue its expected response.
    function void note_request(mmt_pkg::req_t r);
      mmt_pkg::rsp_t e;
      int g, m, i;
      e = '{status: mmt_pkg::StNotFound, member_count: '0, expired_count: '0};
      if (r.op == mmt_pkg::OpAdd) begin
        g = lookup_group(r);
        if (g < 0) begin
          for (g = 0; g < Slots && used[g]; g++);
          if (g < Slots) begin
            used[g] = 1;
            key_net[g] = r.network_id;
            key_mac[g] = r.group_mac;
            key_adi[g] = r.group_adi;
            size[g] = 0;
          end else g = -1;
        end
        if (g < 0) e.status = mmt_pkg::StGroupsFull;
        else begin
          if (r.member_address == self_addr) e.status = mmt_pkg::StSelf;
          else if (size[g] >= MaxMembers) e.status = mmt_pkg::StMembersFull;
          else begin
            m = lookup_member(g, r.member_address);
            if (m >= 0) begin
              seen[g][m] = r.now;
              e.status = mmt_pkg::StRefreshed;
            end else begin
              addr[g][size[g]] = r.member_address;
              seen[g][size[g]] = r.now;
              size[g]++;
              e.status = mmt_pkg::StAdded;
            end
          end
          e.member_count = 9'(size[g]);
        end
      end else if (r.op == mmt_pkg::OpRemove) begin
        g = lookup_group(r);
        if (g >= 0) begin
          m = lookup_member(g, r.member_address);
          if (m >= 0) begin
            compact(g, m);
            e.status = mmt_pkg::StRemoved;
          end
          e.member_count = 9'(size[g]);
        end
      end else if (r.op == mmt_pkg::OpExpire) begin
        for (g = 0; g < Slots; g++) begin
          if (!used[g]) continue;
          i = 0;
          while (i < size[g]) begin
            if (r.now - seen[g][i] > {32'd0, expire_age}) begin
              compact(g, i);
              e.expired_count++;
            end else i++;
          end
          if (size[g] == 0) used[g] = 0;
        end
        e.status = mmt_pkg::StSwept;
      end
      pending_rsp.push_back(e);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Check one accepted response against the oldest expectation.
    task check_response(mmt_pkg::rsp_t got);
      mmt_pkg::rsp_t e;
      if (pending_rsp.size() == 0) begin
        report_mismatch("response with none expected");
        return;
      end
      e = pending_rsp.pop_front();
      if (got.status !== e.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, e.status));
      if (got.member_count !== e.member_count)
        report_mismatch($sformatf("member_count %0d, expected %0d",
                                  got.member_count, e.member_count));
      if (got.expired_count !== e.expired_count)
        report_mismatch($sformatf("expired_count %0d, expected %0d",
                                  got.expired_count, e.expired_count));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  mmt_pkg::req_t in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  mmt_pkg::rsp_t out_o;
  logic cfg_we_i = 1'b0;
  logic [mmt_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [mmt_pkg::CfgDataW-1:0] cfg_data_i = '0;

  membership_scoreboard table_model = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  // Small pools of keys and members so that groups fill and repeat.
  logic [63:0] net_pool [4] = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1234,
                                64'h8000_0000_0000_0001};
  logic [47:0] mac_pool [3] = '{48'h0, 48'hFFFF_FFFF_FFFF, 48'h0100_5E00_0001};
  logic [31:0] adi_pool [3] = '{32'h0, 32'hFFFF_FFFF, 32'h5A5A_A5A5};
  logic [63:0] clock_now = 64'd1000;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  multicast_membership_table uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_i, .out_valid_o, .out_stall_i,
    .out_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // Receiver: random stall and response check.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) table_model.check_response(out_o);
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("multicast_membership_table regression: fail");
      $finish;
    end
  end

  // Send one request beat, with an optional random gap before it. The valid
  // line is dropped only in idle cycles and when draining.
  task automatic send_request(mmt_pkg::req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    table_model.note_request(r);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (table_model.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [mmt_pkg::CfgIdxW-1:0] idx,
                           logic [mmt_pkg::CfgDataW-1:0] data);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    table_model.write_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic mmt_pkg::req_t make_req(logic [1:0] op, int k, logic [39:0] a,
                                             logic [63:0] t);
    mmt_pkg::req_t r;
    r.op = op;
    r.network_id = net_pool[k % 4];
    r.group_mac = mac_pool[(k / 4) % 3];
    r.group_adi = adi_pool[(k / 12) % 3];
    r.member_address = a;
    r.now = t;
    return r;
  endfunction

  // Random request, mostly adds into a few groups with a shared clock.
  function automatic mmt_pkg::req_t random_req(int unsigned group_span);
    mmt_pkg::req_t r;
    int unsigned pick;
    pick = $urandom_range(99);
    clock_now = clock_now + 64'($urandom_range(50000));
    r = make_req(mmt_pkg::OpAdd, int'($urandom_range(group_span - 1)),
                 {32'd0, 8'($urandom_range(40))}, clock_now);
    if (pick < 25) r.op = mmt_pkg::OpRemove;
    else if (pick < 28) r.op = mmt_pkg::OpExpire;
    else if (pick < 30) r.op = 2'd3;
    if (pick >= 90) begin
      r.network_id = {$urandom, $urandom};
      r.group_mac = {16'($urandom), $urandom};
      r.group_adi = $urandom;
      r.member_address = {8'($urandom), $urandom};
      r.now = {$urandom, $urandom};
    end else if (pick >= 86) r.member_address = table_model.self_addr;
    return r;
  endfunction

  initial begin
    mmt_pkg::req_t r;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: self ignore on a new group, add, refresh, remove, misses, op 3.
    write_reg(mmt_pkg::CfgSelfAddress, 40'h12_3456_789A);
    send_request(make_req(mmt_pkg::OpAdd, 0, 40'h12_3456_789A, 64'd0));
    send_request(make_req(mmt_pkg::OpAdd, 0, 40'hFF_FFFF_FFFF, 64'd0));
    send_request(make_req(mmt_pkg::OpAdd, 0, 40'h0, 64'hFFFF_FFFF_FFFF_FFFF));
    send_request(make_req(mmt_pkg::OpAdd, 0, 40'hFF_FFFF_FFFF, 64'd5));
    send_request(make_req(mmt_pkg::OpRemove, 0, 40'hFF_FFFF_FFFF, 64'd0));
    send_request(make_req(mmt_pkg::OpRemove, 0, 40'h55, 64'd0));
    send_request(make_req(mmt_pkg::OpRemove, 35, 40'h0, 64'd0));
    send_request(make_req(mmt_pkg::OpRemove, 0, 40'h0, 64'd0));
    send_request(make_req(2'd3, 0, 40'h0, 64'd0));
    // Time wrap: member seen near the top, swept just after zero.
    send_request(make_req(mmt_pkg::OpAdd, 1, 40'h7, 64'hFFFF_FFFF_FFFF_FFF0));
    write_reg(mmt_pkg::CfgLikeExpire, 40'd100);
    send_request(make_req(mmt_pkg::OpExpire, 0, 40'h0, 64'd10));
    send_request(make_req(mmt_pkg::OpExpire, 0, 40'h0, 64'd200));
    // Fill all group slots, then one more for the full table.
    for (int k = 0; k < Slots; k++)
      send_request(make_req(mmt_pkg::OpAdd, k, 40'h1, 64'd300));
    send_request(make_req(mmt_pkg::OpAdd, Slots, 40'h1, 64'd300));
    write_reg(mmt_pkg::CfgLikeExpire, 40'd0);
    send_request(make_req(mmt_pkg::OpExpire, 0, 40'h0, 64'd301));
    // Fill one member list to the limit, then an add of a present member, which the full list refuses.
    for (int i = 0; i <= MaxMembers; i++)
      send_request(make_req(mmt_pkg::OpAdd, 2, 40'h100 + 40'(i), 64'd400));
    send_request(make_req(mmt_pkg::OpAdd, 2, 40'h100, 64'd400));
    write_reg(mmt_pkg::CfgLikeExpire, 40'hFF_FFFF_FFFF);
    send_request(make_req(mmt_pkg::OpExpire, 0, 40'h0, 64'hFFFF_FFFF_FFFF_FFFF));
    write_reg(mmt_pkg::CfgLikeExpire, 40'd0);
    send_request(make_req(mmt_pkg::OpExpire, 0, 40'h0, 64'hFFFF_FFFF_FFFF_FFFF));

    // Random phases with different idling and register settings.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      write_reg(mmt_pkg::CfgSelfAddress,
                (phase == 3) ? 40'hFF_FFFF_FFFF : 40'(phase + 3));
      write_reg(mmt_pkg::CfgLikeExpire, 40'($urandom_range(400000, 50000)));
      for (int n = 0; n < 200; n++) begin
        r = random_req((phase == 1) ? 20 : 6);
        send_request(r);
      end
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();
    if (table_model.errors == 0) $display("multicast_membership_table regression: pass");
    else $display("multicast_membership_table regression: fail");
    $finish;
  end
endmodule

`default_nettype wire

// File: sim.f
+incdir+src
src/mmt_pkg.sv
src/mmt_member_ram.sv
src/multicast_membership_table.sv
bench/multicast_membership_table_tb.sv
